>>> src/mpam_pkg.sv
// Shared types and constants for the match pair affinity matrix block.
// No dependencies; imported by the controller, the datapath and the top level.
package mpam_pkg;

  localparam int MAX_MATCHES = 64;
  localparam int IDX_W       = $clog2(MAX_MATCHES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int NODE_W      = 10;
  localparam int SCORE_W     = 16;
  localparam int COORD_W     = 16;
  localparam int POINT_W     = 2 * COORD_W;
  localparam int AFF_W       = 17;
  localparam int TOL_W       = 6;
  localparam int TOLQ_W      = TOL_W + 4;
  localparam int WEIGHT_W    = 16;
  localparam int SQ_W        = 2 * COORD_W + 2;
  localparam int ROOT_W      = COORD_W + 2;
  localparam int NUM_W       = WEIGHT_W + TOLQ_W;
  localparam int SQRT_STEPS  = SQ_W / 2;
  localparam int DIV_STEPS   = NUM_W;
  localparam int STEP_W      = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 112;
  localparam int OUT_DATA_W  = 32;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NO_ROW = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_GEO_WEIGHT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GEO_TOL    = 1'b1;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 16'd4096;
  localparam logic [TOL_W-1:0]    TOL_RST    = 6'd20;

  typedef enum logic [3:0] {
    S_IDLE, S_STATUS, S_LATP, S_CHK, S_SQ, S_RTI, S_RT, S_GM, S_DV, S_EMIT
  } mpam_state_t;

  typedef enum logic [1:0] {
    AFF_STATUS, AFF_DIAG, AFF_ZERO, AFF_FULL
  } aff_kind_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             latch_p;
    logic             sq_en;
    logic [1:0]       sq_sel;
    logic             rt_init;
    logic             rt_step;
    logic             geo_load;
    logic             div_step;
    logic             emit;
    aff_kind_t        emit_kind;
    logic [IDX_W-1:0] emit_row;
    logic [IDX_W-1:0] emit_col;
    logic [1:0]       emit_status;
    logic             emit_last;
  } mpam_cmd_t;

  typedef struct packed {
    logic node_eq;
    logic slot_free;
  } mpam_stat_t;

endpackage

>>> src/mpam_datapath.sv
// Datapath: match stores, shared squaring multiplier, two bit-serial square
// roots, restoring divider and the result register. Depends on mpam_pkg.
module mpam_datapath import mpam_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mpam_cmd_t              cmd,
  output mpam_stat_t             stat,
  input  logic [IN_DATA_W-1:0]   in_tdata,
  input  logic                   cfg_valid,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_DATA_W-1:0]  out_tdata,  // row[5:0], column[11:6], affinity[28:12]
  output logic [1:0]             out_tuser,  // status[1:0]
  output logic                   out_tlast
);

  logic [2*NODE_W-1:0] mem_node  [MAX_MATCHES];
  logic [SCORE_W-1:0]  mem_score [MAX_MATCHES];
  logic [POINT_W-1:0]  mem_fpt   [MAX_MATCHES];
  logic [POINT_W-1:0]  mem_wpt   [MAX_MATCHES];

  logic [2*NODE_W-1:0] q_node_r;
  logic [SCORE_W-1:0]  q_score_r;
  logic [POINT_W-1:0]  q_fpt_r, q_wpt_r;
  logic [2*NODE_W-1:0] p_node_r;
  logic [SCORE_W-1:0]  p_score_r;
  logic [POINT_W-1:0]  p_fpt_r, p_wpt_r;

  logic [WEIGHT_W-1:0] weight_r;
  logic [TOL_W-1:0]    tol_r;

  logic [SQ_W-1:0]     acc_f_r, acc_w_r;
  logic [SQ_W-1:0]     v_f_r, v_w_r, res_f_r, res_w_r, bit_r;
  logic [SQ_W-1:0]     v_f_nxt, v_w_nxt, res_f_nxt, res_w_nxt;
  logic [NUM_W-1:0]    num_r;
  logic [TOLQ_W:0]     rem_r;
  logic                geo_on_r;

  logic                out_valid_r, out_last_r;
  logic [IDX_W-1:0]    out_row_r, out_col_r;
  logic [AFF_W-1:0]    out_aff_r;
  logic [1:0]          out_status_r;

  logic signed [COORD_W:0] diff_s;
  logic [COORD_W-1:0]      mag;
  logic [2*COORD_W-1:0]    sq;
  logic [ROOT_W-1:0]       d1, d2, dd;
  logic [TOLQ_W-1:0]       tolq;
  logic [TOLQ_W:0]         rem_sh;
  logic [AFF_W-1:0]        aff;
  logic [WEIGHT_W-1:0]     geo;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= WEIGHT_RST;
      tol_r    <= TOL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GEO_WEIGHT: weight_r <= cfg_data;
        CFG_GEO_TOL:    tol_r    <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // stores: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_node[cmd.wr_addr]  <= {in_tdata[21:12], in_tdata[11:2]};
      mem_score[cmd.wr_addr] <= in_tdata[37:22];
      mem_fpt[cmd.wr_addr]   <= in_tdata[69:38];
      mem_wpt[cmd.wr_addr]   <= in_tdata[101:70];
    end
    if (cmd.rd_en) begin
      q_node_r  <= mem_node[cmd.rd_addr];
      q_score_r <= mem_score[cmd.rd_addr];
      q_fpt_r   <= mem_fpt[cmd.rd_addr];
      q_wpt_r   <= mem_wpt[cmd.rd_addr];
    end
    if (cmd.latch_p) begin
      p_node_r  <= q_node_r;
      p_score_r <= q_score_r;
      p_fpt_r   <= q_fpt_r;
      p_wpt_r   <= q_wpt_r;
    end
  end

  assign stat.node_eq = (p_node_r[NODE_W-1:0] == q_node_r[NODE_W-1:0]) ||
                        (p_node_r[2*NODE_W-1:NODE_W] == q_node_r[2*NODE_W-1:NODE_W]);
  assign stat.slot_free = !out_valid_r || out_tready;

  // one coordinate difference per step through the shared multiplier
  always_comb begin
    case (cmd.sq_sel)
      2'd0: diff_s = $signed({p_fpt_r[15], p_fpt_r[15:0]}) -
                     $signed({q_fpt_r[15], q_fpt_r[15:0]});
      2'd1: diff_s = $signed({p_fpt_r[31], p_fpt_r[31:16]}) -
                     $signed({q_fpt_r[31], q_fpt_r[31:16]});
      2'd2: diff_s = $signed({p_wpt_r[15], p_wpt_r[15:0]}) -
                     $signed({q_wpt_r[15], q_wpt_r[15:0]});
      default: diff_s = $signed({p_wpt_r[31], p_wpt_r[31:16]}) -
                        $signed({q_wpt_r[31], q_wpt_r[31:16]});
    endcase
    if (diff_s[COORD_W]) begin
      mag = COORD_W'(-diff_s);
    end else begin
      mag = diff_s[COORD_W-1:0];
    end
    sq = mag * mag;
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_en) begin
      case (cmd.sq_sel)
        2'd0: acc_f_r <= SQ_W'(sq);
        2'd1: acc_f_r <= acc_f_r + SQ_W'(sq);
        2'd2: acc_w_r <= SQ_W'(sq);
        default: acc_w_r <= acc_w_r + SQ_W'(sq);
      endcase
    end
  end

  // bit-serial integer square roots, one result bit per step
  always_comb begin
    if (v_f_r >= res_f_r + bit_r) begin
      v_f_nxt   = v_f_r - (res_f_r + bit_r);
      res_f_nxt = (res_f_r >> 1) + bit_r;
    end else begin
      v_f_nxt   = v_f_r;
      res_f_nxt = res_f_r >> 1;
    end
    if (v_w_r >= res_w_r + bit_r) begin
      v_w_nxt   = v_w_r - (res_w_r + bit_r);
      res_w_nxt = (res_w_r >> 1) + bit_r;
    end else begin
      v_w_nxt   = v_w_r;
      res_w_nxt = res_w_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rt_init) begin
      v_f_r   <= acc_f_r;
      v_w_r   <= acc_w_r;
      res_f_r <= '0;
      res_w_r <= '0;
      bit_r   <= SQ_W'(1) << (SQ_W - 2);
    end else if (cmd.rt_step) begin
      v_f_r   <= v_f_nxt;
      v_w_r   <= v_w_nxt;
      res_f_r <= res_f_nxt;
      res_w_r <= res_w_nxt;
      bit_r   <= bit_r >> 2;
    end
  end

  assign d1   = res_f_r[ROOT_W-1:0];
  assign d2   = res_w_r[ROOT_W-1:0];
  assign dd   = (d1 > d2) ? d1 - d2 : d2 - d1;
  assign tolq = {tol_r, 4'd0};

  // restoring divider: quotient bits shift into the numerator register
  assign rem_sh = {rem_r[TOLQ_W-1:0], num_r[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.geo_load) begin
      geo_on_r <= (tolq != '0) && (dd < ROOT_W'(tolq));
      num_r    <= NUM_W'(weight_r) * NUM_W'(tolq - dd[TOLQ_W-1:0]);
      rem_r    <= '0;
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, tolq}) begin
        rem_r <= rem_sh - {1'b0, tolq};
        num_r <= {num_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        num_r <= {num_r[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign geo = geo_on_r ? num_r[WEIGHT_W-1:0] : '0;

  always_comb begin
    case (cmd.emit_kind)
      AFF_DIAG: aff = AFF_W'(q_score_r);
      AFF_FULL: aff = AFF_W'(geo) + AFF_W'((AFF_W'(p_score_r) + AFF_W'(q_score_r)) >> 1);
      default:  aff = '0;
    endcase
  end

  // result register: freed when taken, refilled on emit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_row_r    <= cmd.emit_row;
      out_col_r    <= cmd.emit_col;
      out_aff_r    <= aff;
      out_status_r <= cmd.emit_status;
      out_last_r   <= cmd.emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_aff_r, out_col_r, out_row_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

>>> src/mpam_ctrl.sv
// Controller: match count, row and column counters and the sequencer that
// steps the datapath through each matrix entry. Depends on mpam_pkg.
module mpam_ctrl import mpam_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [1:0]           in_op,
  input  logic [IDX_W-1:0]     in_row,
  input  mpam_stat_t           stat,
  output mpam_cmd_t            cmd
);

  mpam_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] row_r, row_nxt, col_r, col_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [1:0]       code_r, code_nxt;
  logic             last_col;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r  <= row_nxt;
    col_r  <= col_nxt;
    step_r <= step_nxt;
    code_r <= code_nxt;
  end

  assign last_col = (CNT_W'(col_r) + CNT_W'(1)) == count_r;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    step_nxt  = step_r;
    code_nxt  = code_r;
    in_tready = 1'b0;
    cmd       = '0;
    cmd.wr_addr     = count_r[IDX_W-1:0];
    cmd.rd_addr     = col_r;
    cmd.emit_row    = row_r;
    cmd.emit_col    = col_r;
    cmd.emit_status = ST_OK;
    cmd.emit_kind   = AFF_FULL;
    cmd.sq_sel      = step_r[1:0];
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (in_op)
            OP_CLEAR: count_nxt = '0;
            OP_LOAD: begin
              if (count_r[IDX_W]) begin
                code_nxt  = ST_FULL;
                row_nxt   = '0;
                state_nxt = S_STATUS;
              end else begin
                cmd.wr_en = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_READ: begin
              row_nxt = in_row;
              if (CNT_W'(in_row) >= count_r) begin
                code_nxt  = ST_NO_ROW;
                state_nxt = S_STATUS;
              end else begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = in_row;
                state_nxt   = S_LATP;
              end
            end
            default: ;
          endcase
        end
      end
      S_STATUS: begin
        cmd.emit_kind   = AFF_STATUS;
        cmd.emit_col    = '0;
        cmd.emit_status = code_r;
        cmd.emit_last   = 1'b1;
        if (stat.slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_LATP: begin
        // row data is in the read register; fetch column zero
        cmd.latch_p = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = '0;
        col_nxt     = '0;
        state_nxt   = S_CHK;
      end
      S_CHK: begin
        step_nxt = '0;
        if (row_r == col_r || stat.node_eq) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        cmd.sq_en = 1'b1;
        step_nxt  = step_r + STEP_W'(1);
        if (step_r[1:0] == 2'd3) begin
          state_nxt = S_RTI;
        end
      end
      S_RTI: begin
        cmd.rt_init = 1'b1;
        step_nxt    = '0;
        state_nxt   = S_RT;
      end
      S_RT: begin
        cmd.rt_step = 1'b1;
        step_nxt    = step_r + STEP_W'(1);
        if (step_r == STEP_W'(SQRT_STEPS - 1)) begin
          state_nxt = S_GM;
        end
      end
      S_GM: begin
        cmd.geo_load = 1'b1;
        step_nxt     = '0;
        state_nxt    = S_DV;
      end
      S_DV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (row_r == col_r) begin
          cmd.emit_kind = AFF_DIAG;
        end else if (stat.node_eq) begin
          cmd.emit_kind = AFF_ZERO;
        end else begin
          cmd.emit_kind = AFF_FULL;
        end
        cmd.emit_last = last_col;
        if (stat.slot_free) begin
          cmd.emit = 1'b1;
          if (last_col) begin
            state_nxt = S_IDLE;
          end else begin
            col_nxt     = col_r + IDX_W'(1);
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = col_r + IDX_W'(1);
            state_nxt   = S_CHK;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

>>> src/match_pair_affinity_matrix.sv
// Top level of the match pair affinity matrix: controller plus datapath.
// Depends on mpam_pkg, mpam_ctrl and mpam_datapath.
//
//   channel | direction | payload
//   in_     | slave     | in_tdata: op, model/frame node, score, points, row
//   out_    | master    | out_tdata: row, column, affinity; tuser status; tlast
//   cfg_    | write     | cfg_index, cfg_data (geo_weight, geo_tolerance)
//
// Clear and load are taken in the idle state; a row read first fetches the
// row, then steps through each entry: the diagonal and shared nodes go straight
// to the emit step, other entries pass 4 squaring steps on the shared multiplier,
// 17 square-root steps and 26 divider steps. Reset (rst_n low, synchronous)
// empties the set and restores the registers. A stalled output holds the
// sequencer at the emit step; input is taken only between items.
module match_pair_affinity_matrix import mpam_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // operation[1:0], model_node[11:2], frame_node[21:12], match_score[37:22],
  // frame_x[53:38], frame_y[69:54], warped_x[85:70], warped_y[101:86],
  // row_index[107:102]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // row[5:0], column[11:6], affinity[28:12]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [1:0]            out_tuser,
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  mpam_cmd_t  cmd;
  mpam_stat_t stat;

  assign cfg_ready = 1'b1;

  mpam_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tdata[1:0]),
    .in_row    (in_tdata[107:102]),
    .stat      (stat),
    .cmd       (cmd)
  );

  mpam_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> tb/match_pair_affinity_matrix_tb.sv
// Self-checking testbench for match_pair_affinity_matrix: loads, clears and row reads
// are checked against a built-in predictor of the affinity matrix.
// Depends on mpam_pkg and the match_pair_affinity_matrix RTL.
`timescale 1ns / 100ps

module match_pair_affinity_matrix_tb;
  import mpam_pkg::*;

  localparam int          CYCLE_LIMIT = 2000000;
  localparam int          SETTLE      = 150;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;

  typedef struct packed {
    logic [5:0]  row;
    logic [5:0]  col;
    logic [16:0] aff;
    logic [1:0]  status;
    logic        last;
  } entry_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // operation, model_node, frame_node, match_score, frame_x, frame_y,
  // warped_x, warped_y, row_index (lowest bit up)
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // row, column, affinity (lowest bit up)
  logic [OUT_DATA_W-1:0] out_tdata;
  // status
  logic [1:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state
  logic [9:0]  mnode [MAX_MATCHES];
  logic [9:0]  fnode [MAX_MATCHES];
  logic [15:0] score [MAX_MATCHES];
  logic [15:0] fpx [MAX_MATCHES], fpy [MAX_MATCHES];
  logic [15:0] wpx [MAX_MATCHES], wpy [MAX_MATCHES];
  int          stored = 0;
  logic [15:0] weight = WEIGHT_RST;
  logic [5:0]  tolerance = TOL_RST;

  entry_t pending_entries[$];
  int     errors = 0;
  int     cycles = 0;
  bit     idle_en = 1'b1;
  bit     hold_req = 1'b0;
  int     hold_left = 0;
  int     stall_left = 0;
  int     warp_dx, warp_dy;

  match_pair_affinity_matrix u_dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 18; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic longint unsigned point_gap(logic [15:0] ax, logic [15:0] ay,
                                                 logic [15:0] bx, logic [15:0] by);
    longint dx, dy;
    dx = longint'($signed(ax)) - longint'($signed(bx));
    dy = longint'($signed(ay)) - longint'($signed(by));
    return root_floor(dx * dx + dy * dy);
  endfunction

  function automatic logic [16:0] affinity_of(int p, int q);
    longint unsigned d1, d2, diff, tolq, geo;
    if (p == q) return {1'b0, score[p]};
    if (mnode[p] == mnode[q] || fnode[p] == fnode[q]) return '0;
    d1 = point_gap(fpx[p], fpy[p], fpx[q], fpy[q]);
    d2 = point_gap(wpx[p], wpy[p], wpx[q], wpy[q]);
    diff = d1 > d2 ? d1 - d2 : d2 - d1;
    tolq = longint'(tolerance) * 16;
    geo = 0;
    if (tolq != 0 && diff < tolq) geo = (longint'(weight) * (tolq - diff)) / tolq;
    return 17'(geo + ((longint'(score[p]) + longint'(score[q])) >> 1));
  endfunction

  // append one expected transaction at the tail of the queue
  function automatic void queue_entry(entry_t e);
    pending_entries.insert(pending_entries.size(), e);
  endfunction

  task automatic predict_item(logic [IN_DATA_W-1:0] d);
    logic [1:0] op;
    int         p, n;
    entry_t     e;
    op = d[1:0];
    p = int'(d[107:102]);
    case (op)
      OP_CLEAR: stored = 0;
      OP_LOAD: begin
        if (stored >= MAX_MATCHES) begin
          e = '{6'd0, 6'd0, 17'd0, ST_FULL, 1'b1};
          queue_entry(e);
        end else begin
          mnode[stored] = d[11:2];
          fnode[stored] = d[21:12];
          score[stored] = d[37:22];
          fpx[stored] = d[53:38];
          fpy[stored] = d[69:54];
          wpx[stored] = d[85:70];
          wpy[stored] = d[101:86];
          stored++;
        end
      end
      OP_READ: begin
        if (p >= stored) begin
          e = '{6'(p), 6'd0, 17'd0, ST_NO_ROW, 1'b1};
          queue_entry(e);
        end else begin
          n = stored;
          for (int q = 0; q < n; q++) begin
            e = '{6'(p), 6'(q), affinity_of(p, q), ST_OK, q + 1 == n};
            queue_entry(e);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(logic [1:0] op, logic [9:0] mn, logic [9:0] fn, logic [15:0] sc,
                           logic [15:0] fx, logic [15:0] fy, logic [15:0] wx,
                           logic [15:0] wy, logic [5:0] row);
    logic [IN_DATA_W-1:0] d;
    int                   gap;
    d = {4'd0, row, wy, wx, fy, fx, sc, fn, mn, op};
    gap = (idle_en && $urandom_range(0, 3) == 0) ? int'($urandom_range(1, 9)) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= d;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_item(d);
  endtask

  task automatic end_stream();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic clear_set();
    send_item(OP_CLEAR, 10'($urandom), 10'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom), 6'($urandom));
  endtask

  task automatic read_row(logic [5:0] row);
    send_item(OP_READ, 10'($urandom), 10'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom), row);
  endtask

  // coherent points keep the geometric term alive; wide ones cover every bit
  task automatic load_random(bit coherent, bit few_nodes);
    logic [9:0]  mn, fn;
    logic [15:0] fx, fy, wx, wy;
    mn = few_nodes ? 10'($urandom_range(0, 7)) : 10'($urandom_range(0, 1023));
    fn = few_nodes ? 10'($urandom_range(0, 7)) : 10'($urandom_range(0, 1023));
    if (coherent) begin
      fx = 16'($urandom_range(0, 4000) - 2000);
      fy = 16'($urandom_range(0, 4000) - 2000);
      wx = 16'(int'($signed(fx)) + warp_dx + $urandom_range(0, 160) - 80);
      wy = 16'(int'($signed(fy)) + warp_dy + $urandom_range(0, 160) - 80);
    end else begin
      fx = 16'($urandom); fy = 16'($urandom); wx = 16'($urandom); wy = 16'($urandom);
    end
    send_item(OP_LOAD, mn, fn, 16'($urandom_range(0, 65535)), fx, fy, wx, wy,
              6'($urandom));
  endtask

  task automatic wait_drained();
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    wait_drained();
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_GEO_WEIGHT) weight = val;
    else tolerance = val[5:0];
  endtask

  // receiver: check each transaction, then pick the next tready
  always @(posedge clk) begin
    entry_t exp_e;
    entry_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[5:0], out_tdata[11:6], out_tdata[28:12], out_tuser, out_tlast};
      if (pending_entries.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected entry row %0d col %0d aff %0d",
                                   got.row, got.col, got.aff);
      end else begin
        exp_e = pending_entries.pop_front();
        if (got != exp_e) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp row %0d col %0d aff %0d st %0d last %0d / got %0d %0d %0d %0d %0d",
                     exp_e.row, exp_e.col, exp_e.aff, exp_e.status, exp_e.last,
                     got.row, got.col, got.aff, got.status, got.last);
        end
      end
    end
    if (hold_req && hold_left == 0) begin
      hold_left = 400;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = int'($urandom_range(1, 9)) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic test_directed();
    read_row(6'd0);
    send_item(OP_LOAD, 10'd0, 10'd0, 16'd0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 6'd0);
    send_item(OP_LOAD, 10'd1023, 10'd1023, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
              16'h7FFF, 6'd63);
    send_item(OP_LOAD, 10'd0, 10'd5, 16'h1000, 16'd160, 16'd0, 16'd160, 16'd0, 6'd0);
    send_item(OP_LOAD, 10'd7, 10'd1023, 16'h0800, 16'd0, 16'd0, 16'd10, 16'd0, 6'd0);
    send_item(OP_LOAD, 10'd9, 10'd9, 16'hFFFF, 16'd0, 16'd320, 16'd0, 16'd0, 6'd0);
    send_item(OP_UNUSED, 10'd3, 10'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd1);
    for (int r = 0; r < 5; r++) read_row(6'(r));
    read_row(6'd5);
    read_row(6'd63);
    clear_set();
    read_row(6'd0);
    end_stream();
  endtask

  task automatic test_config_sweep();
    logic [15:0] weights [4] = '{16'd0, 16'hFFFF, 16'd4096, 16'h5A5A};
    logic [5:0]  tols [4] = '{6'd20, 6'd40, 6'd0, 6'd63};
    for (int s = 0; s < 4; s++) begin
      write_reg(CFG_GEO_WEIGHT, weights[s]);
      write_reg(CFG_GEO_TOL, {10'($urandom), tols[s]});
      warp_dx = $urandom_range(0, 400) - 200;
      warp_dy = $urandom_range(0, 400) - 200;
      clear_set();
      repeat (5) load_random(1'b1, 1'b0);
      load_random(1'b0, 1'b0);
      for (int r = 0; r < 6; r++) read_row(6'(r));
      end_stream();
    end
  endtask

  task automatic test_full_set();
    wait_drained();
    write_reg(CFG_GEO_TOL, 16'd40);
    clear_set();
    repeat (MAX_MATCHES) load_random(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    load_random(1'b1, 1'b0);
    load_random(1'b0, 1'b0);
    read_row(6'd0);
    read_row(6'd63);
    end_stream();
  endtask

  task automatic test_backpressure();
    wait_drained();
    clear_set();
    repeat (6) load_random(1'b1, 1'b1);
    end_stream();
    hold_req = 1'b1;
    for (int i = 0; i < 10; i++) read_row(6'($urandom_range(0, 7)));
    end_stream();
    // sender waits for every result before going on
    wait_drained();
  endtask

  task automatic test_random(int groups);
    int n, k;
    for (int g = 0; g < groups; g++) begin
      warp_dx = $urandom_range(0, 600) - 300;
      warp_dy = $urandom_range(0, 600) - 300;
      clear_set();
      n = int'($urandom_range(1, 8));
      for (int i = 0; i < n; i++) load_random($urandom_range(0, 4) != 0, $urandom_range(0, 2) == 0);
      k = int'($urandom_range(1, 3));
      for (int i = 0; i < k; i++) read_row(6'($urandom_range(0, n - 1)));
      case ($urandom_range(0, 3))
        0: read_row(6'($urandom_range(0, 63)));
        1: send_item(OP_UNUSED, 10'($urandom), 10'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom), 6'($urandom));
        default: ;
      endcase
    end
    end_stream();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_full_set();
    test_backpressure();
    write_reg(CFG_GEO_WEIGHT, 16'd8192);
    write_reg(CFG_GEO_TOL, 16'd25);
    test_random(24);
    // last stretch runs without any idling
    idle_en = 1'b0;
    test_random(8);
    wait_drained();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
